/* hw/rtl/qsr_pkg.sv */
// ----------------------------------------------------------------------------
// qsr_pkg
// Types and constants shared by the quality symbol rebase block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsr_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned SolDepth = 19;

  localparam logic signed [9:0] PrintLow  = 10'sd33;
  localparam logic signed [9:0] PrintHigh = 10'sd126;

  typedef enum logic [CfgIdxW-1:0] {
    RegInputOffset  = 3'd0,
    RegAcceptMin    = 3'd1,
    RegAcceptMax    = 3'd2,
    RegSolexaMode   = 3'd3,
    RegOutMin       = 3'd4,
    RegOutMax       = 3'd5,
    RegOutputOffset = 3'd6
  } qsr_reg_e;

  typedef struct packed {
    logic [6:0]        input_offset;
    logic signed [8:0] accept_min;
    logic signed [8:0] accept_max;
    logic              solexa_mode;
    logic signed [8:0] out_min;
    logic signed [8:0] out_max;
    logic [6:0]        output_offset;
  } qsr_cfg_t;

  // Phred score for Solexa scores -9..9, index = score + 9
  localparam logic [3:0] SolTable [SolDepth] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
    4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
  };

  function automatic logic signed [8:0] sol_score_rebase(logic signed [8:0] s);
    logic [4:0] idx;
    idx = s[4:0] + 5'd9;
    if (s <= -9'sd10) begin
      return 9'sd0;
    end else if (s >= 9'sd10) begin
      return s;
    end else begin
      return signed'({5'b0, SolTable[idx]});
    end
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/qsr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// qsr_cfg_regs
// Configuration register file, write-only, reset to the default encodings.
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [qsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [qsr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output qsr_pkg::qsr_cfg_t                  cfg_o
);
  import qsr_pkg::*;

  qsr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInputOffset:  cfg_d.input_offset  = cfg_wdata_i[6:0];
        RegAcceptMin:    cfg_d.accept_min    = signed'(cfg_wdata_i);
        RegAcceptMax:    cfg_d.accept_max    = signed'(cfg_wdata_i);
        RegSolexaMode:   cfg_d.solexa_mode   = cfg_wdata_i[0];
        RegOutMin:       cfg_d.out_min       = signed'(cfg_wdata_i);
        RegOutMax:       cfg_d.out_max       = signed'(cfg_wdata_i);
        RegOutputOffset: cfg_d.output_offset = cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.input_offset  <= 7'd33;
      cfg_q.accept_min    <= 9'sd0;
      cfg_q.accept_max    <= 9'sd41;
      cfg_q.solexa_mode   <= 1'b0;
      cfg_q.out_min       <= 9'sd0;
      cfg_q.out_max       <= 9'sd41;
      cfg_q.output_offset <= 7'd33;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/qsr_convert.sv */
// ----------------------------------------------------------------------------
// qsr_convert
// Score datapath: offset, accept test, Solexa conversion and clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_convert (
  input  wire qsr_pkg::qsr_cfg_t  cfg_i,
  input  wire logic [7:0]    symbol_i,
  output logic [6:0]         symbol_o,
  output logic               rejected_o
);
  import qsr_pkg::*;

  logic signed [8:0] score;
  logic signed [8:0] conv;
  logic signed [8:0] clamped;
  logic signed [9:0] shifted;
  logic signed [9:0] printable;

  always_comb begin
    score      = signed'({symbol_i[7], symbol_i}) - signed'({2'b00, cfg_i.input_offset});
    rejected_o = (score < cfg_i.accept_min) || (score > cfg_i.accept_max);
    conv       = cfg_i.solexa_mode ? sol_score_rebase(score) : score;

    clamped = conv;
    if (clamped < cfg_i.out_min) clamped = cfg_i.out_min;
    if (clamped > cfg_i.out_max) clamped = cfg_i.out_max;

    shifted   = signed'({clamped[8], clamped}) + signed'({3'b000, cfg_i.output_offset});
    printable = shifted;
    if (printable < PrintLow)  printable = PrintLow;
    if (printable > PrintHigh) printable = PrintHigh;

    symbol_o = rejected_o ? 7'd0 : printable[6:0];
  end

endmodule

`default_nettype wire

/* hw/rtl/quality_symbol_rebase.sv */
// ----------------------------------------------------------------------------
// quality_symbol_rebase
// Rebases sequencing quality bytes between ASCII quality encodings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_symbol_i carries one raw
//   quality byte per item. Output channel out_valid_o / out_stall_i carries
//   out_symbol_o (33..126, or 0) and out_rejected_o for each input item.
//   The byte is captured in an input register, and the conversion runs
//   between that register and the result register (a two-register pipeline).
//   Throughput is one item per cycle while the receiver is not stalling.
//   When the receiver stalls, the result register holds; the input register
//   takes one more item if empty, after which in_stall_o rises until the
//   result is taken.
//   Reset empties both registers and loads the default encodings
//   (offsets 33, accept and output range 0..41, Solexa conversion off).
//   The user writes configuration via cfg_we_i/cfg_idx_i/cfg_wdata_i only
//   while no item is in flight (not enforced); indexes beyond 6 are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module quality_symbol_rebase (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [qsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [qsr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    in_symbol_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [6:0]                         out_symbol_o,
  output logic                               out_rejected_o
);
  import qsr_pkg::*;

  qsr_cfg_t   cfg;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_symbol_q;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_symbol_q;
  logic       out_rejected_q;
  logic [6:0] conv_symbol;
  logic       conv_rejected;
  logic       advance;
  logic       in_take;

  qsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  qsr_convert u_conv (
    .cfg_i      (cfg),
    .symbol_i   (s1_symbol_q),
    .symbol_o   (conv_symbol),
    .rejected_o (conv_rejected)
  );

  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !advance;
  assign in_take     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_take || (s1_valid_q && !advance);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_symbol_q <= in_symbol_i;
    end
    if (advance && s1_valid_q) begin
      out_symbol_q   <= conv_symbol;
      out_rejected_q <= conv_rejected;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_symbol_o   = out_symbol_q;
  assign out_rejected_o = out_rejected_q;

endmodule

`default_nettype wire

/* tb/quality_symbol_rebase_tb.sv */
// ----------------------------------------------------------------------------
// quality_symbol_rebase_tb
// Self-checking bench for the quality symbol rebase block. A score-level
// predictor runs on every accepted item and each result is compared in order
// against it. Directed tests cover reset encodings, offset and range extremes,
// inverted ranges, ignored register writes and the Solexa table; random phases
// then stream bytes under varied encodings with bursty input and a stalling
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module quality_symbol_rebase_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import qsr_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    logic [6:0] symbol;
    logic       rejected;
  } rebase_result_t;

  typedef enum int {StallNone, StallLight, StallPeriodic, StallHeavy} stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] in_symbol_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [6:0] out_symbol_o;
  logic out_rejected_o;

  quality_symbol_rebase dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .in_symbol_i,
    .out_valid_o,
    .out_stall_i,
    .out_symbol_o,
    .out_rejected_o
  );

  always #4 clk_i = ~clk_i;

  qsr_cfg_t       encoding;
  rebase_result_t rebased_q[$];
  int             fail_count = 0;
  int             burst_left = 0;
  int             gap_max = 0;

  function automatic int solexa_score_to_phred(int s);
    if (s <= -10) begin
      return 0;
    end else if (s >= 10) begin
      return s;
    end else if (s <= -4) begin
      return 1;
    end else if (s <= -2) begin
      return 2;
    end else if (s <= 0) begin
      return 3;
    end else if (s <= 2) begin
      return 4;
    end else if (s <= 4) begin
      return 5;
    end else begin
      return s + 1;
    end
  endfunction

  function automatic rebase_result_t rebase_symbol(logic [7:0] raw);
    rebase_result_t r;
    int score;
    int v;
    score = int'($signed(raw)) - int'(encoding.input_offset);
    if (score < int'($signed(encoding.accept_min)) ||
        score > int'($signed(encoding.accept_max))) begin
      r.symbol = '0;
      r.rejected = 1'b1;
      return r;
    end
    v = encoding.solexa_mode ? solexa_score_to_phred(score) : score;
    if (v < int'($signed(encoding.out_min))) v = int'($signed(encoding.out_min));
    if (v > int'($signed(encoding.out_max))) v = int'($signed(encoding.out_max));
    v += int'(encoding.output_offset);
    if (v < 33) v = 33;
    if (v > 126) v = 126;
    r.symbol = 7'(v);
    r.rejected = 1'b0;
    return r;
  endfunction

  // receiver stall pattern under a randomly redrawn mode
  stall_mode_e stall_mode = StallNone;
  int          stall_tick = 0;

  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      StallNone:     out_stall_i <= 1'b0;
      StallLight:    out_stall_i <= ($urandom_range(0, 99) < 30);
      StallPeriodic: out_stall_i <= ((stall_tick % 5) < 2);
      default:       out_stall_i <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // scoreboard
  always @(posedge clk_i) begin : score_check
    rebase_result_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) rebased_q.push_back(rebase_symbol(in_symbol_i));
      if (out_valid_o && !out_stall_i) begin
        if (rebased_q.size() == 0) begin
          $error("result with no item pending: out_symbol %0d rejected %0d",
                 out_symbol_o, out_rejected_o);
          fail_count++;
        end else begin
          want = rebased_q.pop_front();
          if (out_symbol_o !== want.symbol) begin
            $error("out_symbol: expected %0d, actual %0d", want.symbol, out_symbol_o);
            fail_count++;
          end
          if (out_rejected_o !== want.rejected) begin
            $error("rejected: expected %0d, actual %0d", want.rejected, out_rejected_o);
            fail_count++;
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_symbol(logic [7:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_symbol_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and let the pipeline empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (rebased_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high so that writes can go back to back
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegInputOffset:  encoding.input_offset = data[6:0];
      RegAcceptMin:    encoding.accept_min = data;
      RegAcceptMax:    encoding.accept_max = data;
      RegSolexaMode:   encoding.solexa_mode = data[0];
      RegOutMin:       encoding.out_min = data;
      RegOutMax:       encoding.out_max = data;
      RegOutputOffset: encoding.output_offset = data[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_encoding(int in_off, int acc_min, int acc_max, int sol,
                                int o_min, int o_max, int out_off);
    write_reg(RegInputOffset, 9'(in_off));
    write_reg(RegAcceptMin, 9'(acc_min));
    write_reg(RegAcceptMax, 9'(acc_max));
    write_reg(RegSolexaMode, 9'(sol));
    write_reg(RegOutMin, 9'(o_min));
    write_reg(RegOutMax, 9'(o_max));
    write_reg(RegOutputOffset, 9'(out_off));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    send_symbol(8'd33);
    send_symbol(8'd74);
    send_symbol(8'd75);
    send_symbol(8'd32);
    send_symbol(8'd200);
    settle_block();
  endtask

  task automatic test_ignored_index();
    write_reg(RegUnused, 9'h1FF);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_symbol(8'd60);
    settle_block();
  endtask

  task automatic test_offset_extremes();
    apply_encoding(127, -255, 255, 0, -255, 255, 127);
    send_symbol(8'd0);
    send_symbol(8'd255);
    send_symbol(8'd127);
    settle_block();
    apply_encoding(0, -255, 255, 0, -255, 255, 0);
    send_symbol(8'd127);
    send_symbol(8'd128);
    settle_block();
  endtask

  task automatic test_inverted_ranges();
    apply_encoding(33, 10, 5, 0, 0, 41, 33);
    send_symbol(8'd40);
    settle_block();
    apply_encoding(33, 0, 41, 0, 20, 10, 33);
    send_symbol(8'd33);
    settle_block();
  endtask

  task automatic test_solexa_table();
    int scores[12] = '{-11, -10, -9, -4, -3, -1, 0, 1, 3, 5, 9, 10};
    apply_encoding(64, -255, 255, 1, -255, 255, 64);
    foreach (scores[i]) send_symbol(8'(64 + scores[i]));
    settle_block();
  endtask

  task automatic pick_encoding(int kind);
    int amin;
    int amax;
    int omin;
    int omax;
    int t;
    case (kind)
      0: apply_encoding($urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 511), $urandom_range(0, 511),
                        $urandom_range(0, 511));
      1: apply_encoding($urandom_range(0, 1) ? 127 : 0,
                        $urandom_range(0, 1) ? 255 : -255,
                        $urandom_range(0, 1) ? 255 : -255,
                        $urandom_range(0, 1),
                        $urandom_range(0, 1) ? 255 : -255,
                        $urandom_range(0, 1) ? 255 : -255,
                        $urandom_range(0, 1) ? 127 : 0);
      default: begin
        amin = int'($urandom_range(0, 180)) - 140;
        amax = amin + int'($urandom_range(0, 120));
        omin = int'($urandom_range(0, 60)) - 30;
        omax = omin + int'($urandom_range(0, 100));
        if ($urandom_range(0, 5) == 0) begin
          t = omin;
          omin = omax;
          omax = t;
        end
        apply_encoding($urandom_range(0, 127), amin, amax, $urandom_range(0, 1),
                       omin, omax, $urandom_range(0, 127));
      end
    endcase
  endtask

  task automatic test_random_streams();
    int off;
    int lo;
    int hi;
    for (int phase = 0; phase < 16; phase++) begin
      pick_encoding(phase % 4);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      off = int'(encoding.input_offset);
      lo = int'($signed(encoding.accept_min));
      hi = int'($signed(encoding.accept_max));
      if (lo < -128 - off) lo = -128 - off;
      if (hi > 127 - off) hi = 127 - off;
      for (int n = 0; n < 100; n++) begin
        if (lo <= hi && $urandom_range(0, 9) < 7) begin
          send_symbol(8'(lo + int'($urandom_range(0, hi - lo)) + off));
        end else begin
          send_symbol(8'($urandom_range(0, 255)));
        end
      end
      settle_block();
    end
  endtask

  initial begin
    encoding.input_offset = 7'd33;
    encoding.accept_min = 9'sd0;
    encoding.accept_max = 9'sd41;
    encoding.solexa_mode = 1'b0;
    encoding.out_min = 9'sd0;
    encoding.out_max = 9'sd41;
    encoding.output_offset = 7'd33;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_ignored_index();
    test_offset_extremes();
    test_inverted_ranges();
    test_solexa_table();
    test_random_streams();
    settle_block();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/qsr_pkg.sv
hw/rtl/qsr_cfg_regs.sv
hw/rtl/qsr_convert.sv
hw/rtl/quality_symbol_rebase.sv
tb/quality_symbol_rebase_tb.sv
